FILE: hw/rtl/ifp_pkg.sv
// Shared types, constants and CRC helper for the IMU frame parser.
`default_nettype none

package ifp_pkg;

  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;
  localparam logic [6:0]  IdMask   = 7'h7F;
  localparam int unsigned RecBytes = 16;
  localparam int unsigned RecFirst = 4;   // first payload byte kept in the record

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_ATT_LENGTH  = 2'd2,
    CFG_ATT_OBJ_ID  = 2'd3
  } ifp_cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_ATTITUDE = 2'd0,
    KIND_OTHER    = 2'd1,
    KIND_CRC_ERR  = 2'd2
  } ifp_kind_e;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] att_length;
    logic [6:0] att_obj_id;
  } ifp_cfg_t;

  typedef struct packed {
    ifp_kind_e   kind;
    logic [6:0]  object_id;
    logic [31:0] stamp;
    logic [31:0] roll_bits;
    logic [31:0] pitch_bits;
    logic [31:0] yaw_bits;
  } ifp_result_t;

  // CRC-16/MODBUS update by one byte, reflected, bit at a time
  function automatic logic [15:0] crc16_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/imu_frame_parser_crc16_top.sv
// Top level of the IMU frame parser with CRC-16/MODBUS check.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------------
//   cfg     | in        | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//   rx      | in        | in_valid_i / in_ready_o  | rx_byte_i
//   result  | out       | out_valid_o / out_ready_i| frame_kind_o, object_id_o, stamp_o,
//           |           |                          | roll/pitch/yaw_bits_o
//
// One byte per cycle unless stalled; the CRC byte update is one pass of logic after crc_q.
// A result appears in the output register in the cycle after the last CRC byte transfer.
// Input stalls only when the byte would end a frame while a held result is not being taken.
// Reset (async, active low) returns to header hunt with the CRC at 0xFFFF.
`default_nettype none

module imu_frame_parser_crc16_top
  import ifp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       frame_kind_o,
  output logic [6:0]       object_id_o,
  output logic [31:0]      stamp_o,
  output logic [31:0]      roll_bits_o,
  output logic [31:0]      pitch_bits_o,
  output logic [31:0]      yaw_bits_o
);

  ifp_cfg_t    cfg;
  ifp_result_t res_new, res_out;
  logic        at_last, res_valid, take;

  ifp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign in_ready_o = !at_last || !out_valid_o || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  ifp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .take_i      (take),
    .byte_i      (rx_byte_i),
    .at_last_o   (at_last),
    .res_valid_o (res_valid),
    .res_o       (res_new)
  );

  ifp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res_new),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign frame_kind_o = 2'(res_out.kind);
  assign object_id_o  = res_out.object_id;
  assign stamp_o      = res_out.stamp;
  assign roll_bits_o  = res_out.roll_bits;
  assign pitch_bits_o = res_out.pitch_bits;
  assign yaw_bits_o   = res_out.yaw_bits;

endmodule

`default_nettype wire

FILE: hw/rtl/ifp_cfg_regs.sv
// Configuration registers of the IMU frame parser.
`default_nettype none

module ifp_cfg_regs
  import ifp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i,
  output ifp_cfg_t        cfg_o
);

  ifp_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ifp_cfg_idx_e'(cfg_idx_i))
        CFG_SYNC_FIRST:  cfg_d.sync_first  = cfg_wdata_i;
        CFG_SYNC_SECOND: cfg_d.sync_second = cfg_wdata_i;
        CFG_ATT_LENGTH:  cfg_d.att_length  = cfg_wdata_i;
        CFG_ATT_OBJ_ID:  cfg_d.att_obj_id  = cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= 8'd170;
      cfg_q.sync_second <= 8'd85;
      cfg_q.att_length  <= 8'd20;
      cfg_q.att_obj_id  <= 7'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ifp_parser.sv
// Frame state machine, CRC accumulation and record capture.
`default_nettype none

module ifp_parser
  import ifp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ifp_cfg_t   cfg_i,
  input  wire logic       take_i,
  input  wire logic [7:0] byte_i,
  output logic            at_last_o,  // next byte closes a frame
  output logic            res_valid_o,
  output ifp_result_t     res_o
);

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRCLO   = 3'd4,
    PH_CRCHI   = 3'd5
  } phase_e;

  phase_e      phase_q;
  logic [8:0]  count_q;
  logic [7:0]  flen_q;
  logic [15:0] crc_q;
  logic [7:0]  tail_lo_q;
  logic [7:0]  first_q;
  logic [7:0]  rec_q [RecBytes];

  logic [8:0]  count_inc;
  logic [8:0]  rec_off;
  logic [15:0] crc_next;
  logic [6:0]  id;

  assign count_inc = count_q + 9'd1;
  assign rec_off   = count_q - 9'(RecFirst);
  assign crc_next  = crc16_feed(crc_q, byte_i);
  assign id        = first_q[6:0] & IdMask;
  assign at_last_o = (phase_q == PH_CRCHI);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      count_q <= '0;
      flen_q  <= '0;
      crc_q   <= CrcInit;
    end else if (take_i) begin
      case (phase_q)
        PH_HUNT2: begin
          if (byte_i == cfg_i.sync_second) begin
            phase_q <= PH_LEN;
          end else begin
            phase_q <= PH_HUNT1;
            count_q <= '0;
            flen_q  <= '0;
            crc_q   <= CrcInit;
          end
        end
        PH_LEN: begin
          flen_q  <= byte_i;
          count_q <= '0;
          crc_q   <= crc16_feed(CrcInit, byte_i);
          phase_q <= (byte_i == 8'd0) ? PH_CRCLO : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          crc_q   <= crc_next;
          count_q <= count_inc;
          if (count_inc >= {1'b0, flen_q}) begin
            phase_q <= PH_CRCLO;
          end
        end
        PH_CRCLO: begin
          phase_q <= PH_CRCHI;
        end
        PH_CRCHI: begin
          phase_q <= PH_HUNT1;
          count_q <= '0;
          flen_q  <= '0;
          crc_q   <= CrcInit;
        end
        default: begin
          phase_q <= (byte_i == cfg_i.sync_first) ? PH_HUNT2 : PH_HUNT1;
          count_q <= '0;
          flen_q  <= '0;
          crc_q   <= CrcInit;
        end
      endcase
    end
  end

  // payload capture; cleared at each length byte so short frames read zero
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      if (phase_q == PH_LEN) begin
        first_q <= '0;
        for (int i = 0; i < RecBytes; i++) begin
          rec_q[i] <= '0;
        end
      end else if (phase_q == PH_PAYLOAD) begin
        if (count_q == 9'd0) begin
          first_q <= byte_i;
        end
        if (count_q >= 9'(RecFirst) && count_q < 9'(RecFirst + RecBytes)) begin
          rec_q[rec_off[3:0]] <= byte_i;
        end
      end
      if (phase_q == PH_CRCLO) begin
        tail_lo_q <= byte_i;
      end
    end
  end

  always_comb begin
    res_valid_o = take_i && (phase_q == PH_CRCHI);
    res_o       = '0;
    if ({byte_i, tail_lo_q} != crc_q) begin
      res_o.kind = KIND_CRC_ERR;
    end else if (id == cfg_i.att_obj_id && flen_q == cfg_i.att_length) begin
      res_o.kind       = KIND_ATTITUDE;
      res_o.object_id  = id;
      res_o.stamp      = {rec_q[3],  rec_q[2],  rec_q[1],  rec_q[0]};
      res_o.roll_bits  = {rec_q[7],  rec_q[6],  rec_q[5],  rec_q[4]};
      res_o.pitch_bits = {rec_q[11], rec_q[10], rec_q[9],  rec_q[8]};
      res_o.yaw_bits   = {rec_q[15], rec_q[14], rec_q[13], rec_q[12]};
    end else begin
      res_o.kind      = KIND_OTHER;
      res_o.object_id = id;
    end
  end

  a_crchi_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && phase_q == PH_CRCHI |=> phase_q == PH_HUNT1)
    else $error("frame end did not restart the hunt");

  a_zero_len_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && phase_q == PH_LEN && byte_i == 8'd0 |=> phase_q == PH_CRCLO)
    else $error("zero length frame did not go to CRC bytes");

  a_crclo_before_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CRCHI && !$past(phase_q == PH_CRCHI) |-> $past(phase_q == PH_CRCLO))
    else $error("CRC high byte phase entered without low byte");

  a_len_reset_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && phase_q == PH_HUNT2 && byte_i != cfg_i.sync_second
    |=> phase_q == PH_HUNT1 && crc_q == CrcInit)
    else $error("bad second header did not restart the hunt");

endmodule

`default_nettype wire

FILE: hw/rtl/ifp_out_stage.sv
// Output register holding one result until the downstream transfer.
`default_nettype none

module ifp_out_stage
  import ifp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire ifp_result_t res_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output ifp_result_t      res_o
);

  logic        valid_q;
  ifp_result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire
